>>> design/igoc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the gyroscope offset calibrator.
// No dependencies; imported by every module of the block.
package igoc_pkg;

    localparam int AXIS_W     = 16;
    localparam int AXES       = 3;
    localparam int BYTES_W    = AXES * AXIS_W;
    localparam int CFG_ADDR_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_VALID    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET_X = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET_Y = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET_Z = 2'd3;

    // Three 16-bit axes; element 0 is X.
    typedef logic [AXES-1:0][AXIS_W-1:0] vec3_t;

    // Handshake between the controller and the offset divider.
    typedef struct packed {
        logic start;
        logic ack;
    } div_req_t;

    // Split six big-endian bytes (X first) into three axes.
    function automatic vec3_t unpack3(input logic [BYTES_W-1:0] b);
        vec3_t v;
        v[0] = b[47:32];
        v[1] = b[31:16];
        v[2] = b[15:0];
        return v;
    endfunction

endpackage

>>> design/igoc_axis_path.sv
`timescale 1ns / 1ps
// Gyroscope axis path: byte unpacking, offset subtraction and dead band.
// Depends on igoc_pkg.
module igoc_axis_path #(
    parameter int DEADBAND = 5
) (
    input  logic [igoc_pkg::BYTES_W-1:0] gyro_bytes,
    input  igoc_pkg::vec3_t              offsets,
    output igoc_pkg::vec3_t              gyro
);
    import igoc_pkg::*;

    localparam logic signed [AXIS_W-1:0] DB_POS = AXIS_W'(DEADBAND);
    localparam logic signed [AXIS_W-1:0] DB_NEG = -DB_POS;

    vec3_t raw;
    vec3_t diff;

    always_comb
    begin
        raw = unpack3(gyro_bytes);
        for (int i = 0; i < AXES; i++)
        begin
            // The subtraction wraps to 16 bits by design.
            diff[i] = raw[i] - offsets[i];
            if ($signed(diff[i]) < DB_POS && $signed(diff[i]) > DB_NEG)
                gyro[i] = '0;
            else
                gyro[i] = diff[i];
        end
    end

endmodule

>>> design/igoc_divider.sv
`timescale 1ns / 1ps
// Three-stage divider of the calibration sums by SAMPLES, truncating toward zero,
// using a multiply by a reciprocal constant. Depends on igoc_pkg.
module igoc_divider #(
    parameter int SAMPLES = 200
) (
    input  logic                                                     clk,
    input  logic                                                     rst_n,
    input  igoc_pkg::div_req_t                                       req,
    input  logic [igoc_pkg::AXES-1:0][igoc_pkg::AXIS_W+$clog2(SAMPLES)-1:0] sums,
    output igoc_pkg::vec3_t                                          quot,
    output logic                                                     quot_valid
);
    import igoc_pkg::*;

    localparam int SUM_W   = AXIS_W + $clog2(SAMPLES);
    localparam int CLG     = $clog2(SAMPLES);
    localparam int SHIFT   = SUM_W + CLG;
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int Q_W     = PROD_W - SHIFT;
    // Smallest m with m * SAMPLES >= 2^SHIFT; exact for magnitudes below 2^SUM_W.
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

    logic [AXES-1:0][SUM_W-1:0]  sum_reg;
    logic [AXES-1:0][SUM_W-1:0]  mag_reg;
    logic [AXES-1:0][PROD_W-1:0] prod_reg;
    logic [AXES-1:0]             neg2_reg;
    logic [AXES-1:0]             neg3_reg;
    logic                        v1_reg;
    logic                        v2_reg;
    logic                        v3_reg;
    logic                        v3_next;

    always_comb
    begin
        if (v2_reg)
            v3_next = 1'b1;
        else if (req.ack)
            v3_next = 1'b0;
        else
            v3_next = v3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= req.start;
            v2_reg <= v1_reg;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
            sum_reg <= sums;
        for (int i = 0; i < AXES; i++)
        begin
            if (v1_reg)
            begin
                neg2_reg[i] <= sum_reg[i][SUM_W-1];
                mag_reg[i]  <= sum_reg[i][SUM_W-1] ? (~sum_reg[i] + 1'b1) : sum_reg[i];
            end
            if (v2_reg)
            begin
                neg3_reg[i] <= neg2_reg[i];
                prod_reg[i] <= PROD_W'(mag_reg[i]) * PROD_W'(RECIP);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            logic [Q_W-1:0] q;
            q = prod_reg[i][PROD_W-1:SHIFT];
            if (neg3_reg[i])
                q = ~q + 1'b1;
            quot[i] = q[AXIS_W-1:0];
        end
    end

    assign quot_valid = v3_reg;

    // Only one division is ever in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones({v1_reg, v2_reg, v3_reg}) <= 1)
        else $error("divider holds more than one division");

    assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !(v1_reg || v2_reg || v3_reg))
        else $error("divider started while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        req.ack |-> v3_reg)
        else $error("quotient taken before it was ready");

endmodule

>>> design/imu_gyro_offset_calibrator.sv
`timescale 1ns / 1ps
// Gyroscope offset calibrator: input register, axis path, calibration control, result register.
// One beat per cycle unless the output or divider stalls; a result passes through the input and
// result registers, and while it waits downstream the input register takes one more beat before
// the input stalls. The closing calibration beat stalls the input for the three-stage divider.
// Reset (rst_n, asynchronous, active low) empties both registers, clears the calibration
// state and sets all configuration registers to zero. Depends on igoc_pkg and the submodules.
module imu_gyro_offset_calibrator #(
    parameter int SAMPLES  = 200,
    parameter int DEADBAND = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [95:0]                   s_tdata,  // accel_bytes, gyro_bytes
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, offset_x, offset_y, offset_z
    output logic [143:0]                  m_tdata,
    output logic [1:0]                    m_tuser,  // calibrating, calibration_done
    input  logic                          cfg_we,
    input  logic [igoc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [igoc_pkg::AXIS_W-1:0]   cfg_wdata
);
    import igoc_pkg::*;

    localparam int SUM_W = AXIS_W + $clog2(SAMPLES);
    localparam int CNT_W = $clog2(SAMPLES + 1);

    // Configuration registers.
    logic  cfg_valid_reg;
    vec3_t cfg_off_reg;

    // Calibration state.
    logic                      started_reg;
    logic                      valid_reg;
    vec3_t                     off_reg;
    logic [AXES-1:0][SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0]          cnt_reg;

    // Input and result registers.
    logic        in_valid_reg;
    logic [95:0] in_data_reg;
    logic        launched_reg;
    logic        out_valid_reg;
    logic [143:0] out_data_reg;
    logic [1:0]  out_user_reg;

    logic                      eff_valid;
    vec3_t                     eff_off;
    vec3_t                     acc;
    vec3_t                     gyr;
    vec3_t                     quot;
    logic                      quot_valid;
    logic                      cal;
    logic                      first;
    logic                      last;
    logic [CNT_W-1:0]          cnt_cur;
    logic [AXES-1:0][SUM_W-1:0] sum_new;
    vec3_t                     off_next;
    logic [CNT_W-1:0]          cnt_next;
    logic                      out_space;
    logic                      advance;
    div_req_t                  div_req;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_valid_reg <= 1'b0;
            cfg_off_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_VALID:    cfg_valid_reg  <= cfg_wdata[0];
                CFG_OFFSET_X: cfg_off_reg[0] <= cfg_wdata;
                CFG_OFFSET_Y: cfg_off_reg[1] <= cfg_wdata;
                CFG_OFFSET_Z: cfg_off_reg[2] <= cfg_wdata;
            endcase
        end
    end

    // Before the first beat the configuration stands in for the state.
    assign eff_valid = started_reg ? valid_reg : cfg_valid_reg;
    assign eff_off   = started_reg ? off_reg : cfg_off_reg;

    assign acc = unpack3(in_data_reg[47:0]);

    igoc_axis_path #(
        .DEADBAND (DEADBAND)
    ) u_axis_path (
        .gyro_bytes (in_data_reg[95:48]),
        .offsets    (eff_off),
        .gyro       (gyr)
    );

    always_comb
    begin
        cal     = !eff_valid;
        first   = cal && (cnt_reg == '0);
        cnt_cur = first ? CNT_W'(1) : cnt_reg;
        last    = cal && (cnt_cur == CNT_W'(SAMPLES));
        for (int i = 0; i < AXES; i++)
            sum_new[i] = (first ? '0 : sum_reg[i]) + SUM_W'($signed(gyr[i]));

        // The first calibration beat is corrected with the old offsets, then they are zeroed.
        if (last)
            off_next = quot;
        else if (first)
            off_next = '0;
        else
            off_next = eff_off;

        if (last)
            cnt_next = '0;
        else if (cal)
            cnt_next = CNT_W'(cnt_cur + 1'b1);
        else
            cnt_next = cnt_reg;
    end

    assign out_space     = !out_valid_reg || m_tready;
    assign advance       = in_valid_reg && out_space && (!last || quot_valid);
    assign div_req.start = in_valid_reg && last && !launched_reg;
    assign div_req.ack   = advance && last;
    assign s_tready      = !in_valid_reg || advance;

    igoc_divider #(
        .SAMPLES (SAMPLES)
    ) u_divider (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (div_req),
        .sums       (sum_new),
        .quot       (quot),
        .quot_valid (quot_valid)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            valid_reg     <= 1'b0;
            off_reg       <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            in_valid_reg  <= 1'b0;
            launched_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                launched_reg <= 1'b0;
            else if (div_req.start)
                launched_reg <= 1'b1;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                started_reg <= 1'b1;
                valid_reg   <= eff_valid || last;
                off_reg     <= off_next;
                cnt_reg     <= cnt_next;
                if (cal)
                    sum_reg <= sum_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_data_reg <= s_tdata;
        if (advance)
        begin
            out_data_reg <= {off_next, gyr, acc};
            out_user_reg <= {last, cal};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_user_reg[1]) |-> out_user_reg[0])
        else $error("calibration done on a beat that was not calibrating");

    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && last) |=> (valid_reg && cnt_reg == '0))
        else $error("offsets not marked valid after calibration");

    assert property (@(posedge clk) disable iff (!rst_n)
        launched_reg |-> in_valid_reg)
        else $error("division running without a held beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(SAMPLES))
        else $error("sample count beyond the calibration length");

endmodule
